@@ hdl/eksd_pkg.sv @@
// ----------------------------------------------------------------------------
// eksd_pkg - escaped key string decoder definitions
// Register map, result codes, frame status codes, marker bytes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package eksd_pkg;

  // register map, word index
  localparam int unsigned REG_DESCENDING_MODE = 0;

  localparam logic [7:0] MARKER_ASC  = 8'h00;
  localparam logic [7:0] MARKER_DESC = 8'hFF;
  localparam logic [7:0] ESCAPE_FLIP = 8'h01;

  typedef enum logic [2:0] {
    KIND_DATA       = 3'd0,
    KIND_MARKER     = 3'd1,
    KIND_TERM       = 3'd2,
    KIND_AFTER_TERM = 3'd3,
    KIND_AFTER_ERR  = 3'd4,
    KIND_BAD_ESC    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STAT_TERM_OK = 2'd0,
    STAT_OPEN_OK = 2'd1,
    STAT_TRUNC   = 2'd2,
    STAT_BAD_ESC = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        frame_done;
    status_t     status;
    logic [15:0] count;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/escaped_key_string_decoder.sv @@
// ----------------------------------------------------------------------------
// escaped_key_string_decoder
// Decodes an order-preserving escaped key string, one encoded byte per transfer.
// ----------------------------------------------------------------------------
// channel   | direction | signals                                  | content
// s_axis    | in        | s_tvalid s_tready s_tdata s_tlast        | encoded byte, frame end
// m_axis    | out       | m_tvalid m_tready m_tdata m_tuser m_tlast| result per byte
// apb       | in        | psel penable pwrite paddr pwdata prdata  | descending_mode
//
// One result per input byte, one byte per cycle while the skid stage is empty.
// The marker-pending flag and the saturating byte count update together on
// each accepted byte; that loop sets the rate.
// A skid register behind the output register keeps the input open for one
// more transfer while m_tready is low; s_tready drops once it is full.
// rst is synchronous: frame state, valids and descending_mode clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_key_string_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // in_last
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [7:0] out_byte, [9:8] frame_status,
                                      // [25:10] consumed_count, [31:26] zero
  output logic      [2:0]  m_tuser,   // [2:0] out_kind
  output logic             m_tlast    // frame_done
);

  localparam logic [15:0] CountCap =
    (MAX_FRAME_BYTES > 32'd65535) ? 16'hFFFF : MAX_FRAME_BYTES[15:0];

  logic descending_mode;

  logic        marker_pending, marker_pending_next;
  logic        terminated_seen, terminated_seen_next;
  logic        error_seen, error_seen_next;
  logic [15:0] byte_count, byte_count_next;

  eksd_pkg::res_t res_next;
  eksd_pkg::res_t out_res;
  eksd_pkg::res_t skid_res;
  logic           out_valid;
  logic           skid_valid;

  logic       accept;
  logic       cfg_write;
  logic [7:0] marker;
  logic [7:0] escape;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == 1'(eksd_pkg::REG_DESCENDING_MODE));

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(eksd_pkg::REG_DESCENDING_MODE)) begin
      prdata[0] = descending_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descending_mode <= 1'b0;
    end else if (cfg_write) begin
      descending_mode <= pwdata[0];
    end
  end

  // decode
  assign marker = descending_mode ? eksd_pkg::MARKER_DESC : eksd_pkg::MARKER_ASC;
  assign escape = marker ^ eksd_pkg::ESCAPE_FLIP;

  always_comb begin
    logic count_it;
    count_it             = 1'b0;
    marker_pending_next  = marker_pending;
    terminated_seen_next = terminated_seen;
    error_seen_next      = error_seen;
    res_next.kind        = eksd_pkg::KIND_DATA;
    res_next.data_byte   = '0;
    res_next.frame_done  = s_tlast;
    res_next.status      = eksd_pkg::STAT_TERM_OK;
    res_next.count       = '0;

    priority if (terminated_seen) begin
      res_next.kind = eksd_pkg::KIND_AFTER_TERM;
    end else if (error_seen) begin
      res_next.kind = eksd_pkg::KIND_AFTER_ERR;
    end else if (marker_pending) begin
      marker_pending_next = 1'b0;
      priority if (s_tdata == marker) begin
        res_next.kind        = eksd_pkg::KIND_TERM;
        terminated_seen_next = 1'b1;
        count_it             = 1'b1;
      end else if (s_tdata == escape) begin
        count_it = 1'b1;
      end else begin
        res_next.kind   = eksd_pkg::KIND_BAD_ESC;
        error_seen_next = 1'b1;
      end
    end else if (s_tdata == marker) begin
      res_next.kind       = eksd_pkg::KIND_MARKER;
      marker_pending_next = 1'b1;
      count_it            = 1'b1;
    end else begin
      res_next.data_byte = s_tdata ^ marker;
      count_it           = 1'b1;
    end

    // saturating count
    byte_count_next = (count_it && (byte_count < CountCap)) ? byte_count + 16'd1
                                                            : byte_count;

    if (s_tlast) begin
      priority if (error_seen_next) begin
        res_next.status = eksd_pkg::STAT_BAD_ESC;
      end else if (marker_pending_next) begin
        res_next.status = eksd_pkg::STAT_TRUNC;
      end else if (terminated_seen_next) begin
        res_next.status = eksd_pkg::STAT_TERM_OK;
        res_next.count  = byte_count_next;
      end else begin
        res_next.status = eksd_pkg::STAT_OPEN_OK;
        res_next.count  = byte_count_next;
      end
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_pending  <= 1'b0;
      terminated_seen <= 1'b0;
      error_seen      <= 1'b0;
      byte_count      <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        marker_pending  <= 1'b0;
        terminated_seen <= 1'b0;
        error_seen      <= 1'b0;
        byte_count      <= '0;
      end else begin
        marker_pending  <= marker_pending_next;
        terminated_seen <= terminated_seen_next;
        error_seen      <= error_seen_next;
        byte_count      <= byte_count_next;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_next;
      end
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.frame_done;
  assign m_tdata  = {6'b0, out_res.count, out_res.status, out_res.data_byte};

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (!marker_pending && !terminated_seen && !error_seen
                             && (byte_count == 16'd0)))
    else $error("frame state not cleared after frame end");

  a_term_err_excl: assert property (@(posedge clk) disable iff (rst)
    !(terminated_seen && error_seen))
    else $error("terminator and error both recorded");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CountCap)
    else $error("byte count above its bound");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.kind != eksd_pkg::KIND_DATA)) |-> (out_res.data_byte == 8'h00))
    else $error("non-data result carries a byte");

endmodule

`default_nettype wire

@@ tb/sv/tb_escaped_key_string_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escaped_key_string_decoder - self-checking bench for the key string decoder
// Streams encoded key frames in both marker modes through the block under
// random source gaps and sink stalls. Every output transfer is compared with
// a cycle-free prediction of the decode. Directed frames cover escapes,
// terminators, truncation, bad escapes and a mode change inside an open frame.
// Random frames are mostly well formed with random content.
// ----------------------------------------------------------------------------

module tb_escaped_key_string_decoder;

  localparam int unsigned FRAME_CAP    = 65535;
  localparam int unsigned WATCHDOG_MAX = 4000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned SETTLE_WAIT  = 20;
  localparam logic [2:0]  MODE_ADDR    = 3'(eksd_pkg::REG_DESCENDING_MODE * 4);
  localparam logic [7:0]  ESC_ASC      = eksd_pkg::MARKER_ASC ^ eksd_pkg::ESCAPE_FLIP;
  localparam logic [7:0]  ESC_DESC     = eksd_pkg::MARKER_DESC ^ eksd_pkg::ESCAPE_FLIP;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] in_byte
  logic        s_tlast  = 1'b0; // in_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [7:0] out_byte, [9:8] frame_status, [25:10] consumed_count
  logic [2:0]  m_tuser;         // [2:0] out_kind
  logic        m_tlast;         // frame_done

  // decode predictor and store of expected results
  class key_decode_model;
    bit             desc;
    bit             marker_held;
    bit             term_seen;
    bit             err_seen;
    bit [15:0]      consumed;
    eksd_pkg::res_t expected_results[$];
    int             mismatches;
    int             checked;
    int             frames;

    function void set_mode(bit m);
      desc = m;
    endfunction

    function void count_one();
      if (consumed < 16'(FRAME_CAP)) consumed++;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [7:0]     mk;
      logic [7:0]     esc;
      eksd_pkg::res_t r;
      mk = desc ? eksd_pkg::MARKER_DESC : eksd_pkg::MARKER_ASC;
      esc = mk ^ eksd_pkg::ESCAPE_FLIP;
      r = '0;
      r.kind = eksd_pkg::KIND_DATA;
      r.status = eksd_pkg::STAT_TERM_OK;
      if (term_seen) begin
        r.kind = eksd_pkg::KIND_AFTER_TERM;
      end else if (err_seen) begin
        r.kind = eksd_pkg::KIND_AFTER_ERR;
      end else if (marker_held) begin
        marker_held = 1'b0;
        if (b == mk) begin
          r.kind = eksd_pkg::KIND_TERM;
          term_seen = 1'b1;
          count_one();
        end else if (b == esc) begin
          count_one();
        end else begin
          r.kind = eksd_pkg::KIND_BAD_ESC;
          err_seen = 1'b1;
        end
      end else if (b == mk) begin
        r.kind = eksd_pkg::KIND_MARKER;
        marker_held = 1'b1;
        count_one();
      end else begin
        r.data_byte = b ^ mk;
        count_one();
      end
      if (last) begin
        r.frame_done = 1'b1;
        if (err_seen) begin
          r.status = eksd_pkg::STAT_BAD_ESC;
        end else if (marker_held) begin
          r.status = eksd_pkg::STAT_TRUNC;
        end else begin
          r.status = term_seen ? eksd_pkg::STAT_TERM_OK : eksd_pkg::STAT_OPEN_OK;
          r.count = consumed;
        end
        marker_held = 1'b0;
        term_seen = 1'b0;
        err_seen = 1'b0;
        consumed = '0;
        frames++;
      end
      expected_results = {expected_results, r};
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] b, logic done,
                               logic [1:0] st, logic [15:0] cnt);
      eksd_pkg::res_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: kind %0d byte %h", kind, b);
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (kind !== e.kind || b !== e.data_byte || done !== e.frame_done ||
          st !== e.status || cnt !== e.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d (expected/actual): kind %0d/%0d byte %h/%h",
                   checked, e.kind, kind, e.data_byte, b);
          $display("  done %0b/%0b frame status %0d/%0d count %0d/%0d",
                   e.frame_done, done, e.status, st, e.count, cnt);
        end
      end
    endfunction
  endclass

  key_decode_model sb = new();

  logic [7:0] frame_bytes[$];
  bit         burst;
  bit         hold_request;
  int         holds;
  int         sent;
  int         idle_cycles;
  int         send_left;
  bit         send_calm;

  escaped_key_string_decoder #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_MAX);
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
    $display("status: fail");
    $finish;
  end

  // sink side: random stalls, calm stretches and one long hold-off on request
  initial begin
    int stall;
    int left;
    bit calm;
    left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (left == 0) begin
        left = 32;
        calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      stall = calm ? 0 : $urandom_range(0, 19);
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
        holds++;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tuser, m_tdata[7:0], m_tlast, m_tdata[9:8], m_tdata[25:10]);
    end
  end

  function automatic void add_byte(logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (send_left == 0) begin
      send_left = 32;
      send_calm = ($urandom_range(0, 3) == 0);
    end
    send_left--;
    gap = (burst || send_calm) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, last);
    sent++;
  endtask

  task automatic send_frame(bit close);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], close && (i == frame_bytes.size() - 1));
    frame_bytes.delete();
  endtask

  // source pauses until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  // write the mode register, then read it back
  task automatic write_mode(bit m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_mode(m);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, m}) begin
      sb.mismatches++;
      if (sb.mismatches <= 10) $display("mode read back %h, expected %0d", prdata, m);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // raw key byte, biased towards the values that collide with markers
  function automatic logic [7:0] pick_raw();
    case ($urandom_range(0, 5))
      0:       return eksd_pkg::MARKER_ASC;
      1:       return eksd_pkg::MARKER_DESC;
      2:       return ESC_ASC;
      3:       return ESC_DESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_frame();
    int         shape;
    int         n;
    logic [7:0] mk;
    logic [7:0] esc;
    logic [7:0] b;
    mk = sb.desc ? eksd_pkg::MARKER_DESC : eksd_pkg::MARKER_ASC;
    esc = mk ^ eksd_pkg::ESCAPE_FLIP;
    shape = $urandom_range(0, 9);
    n = $urandom_range(0, 10);
    frame_bytes.delete();
    if (shape == 9) begin
      // noise
      repeat (n + 1) add_byte(pick_raw());
    end else begin
      repeat (n) begin
        b = pick_raw();
        if (b == 8'h00) begin
          add_byte(mk);
          add_byte(esc);
        end else begin
          add_byte(b ^ mk);
        end
      end
      case (shape)
        6: if (frame_bytes.size() == 0) add_byte(8'h5A ^ mk);
        7: add_byte(mk);
        8: begin
          do b = 8'($urandom_range(0, 255)); while (b == mk || b == esc);
          add_byte(mk);
          add_byte(b);
          repeat ($urandom_range(0, 2)) add_byte(pick_raw());
        end
        default: begin
          add_byte(mk);
          add_byte(mk);
          repeat ($urandom_range(0, 2)) add_byte(pick_raw());
        end
      endcase
    end
  endtask

  initial begin
    int phase_count;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ascending marker: data, escaped zero, 0xff, terminator, trailing bytes
    write_mode(1'b0);
    frame_bytes = {8'h41, eksd_pkg::MARKER_ASC, ESC_ASC, 8'hFF, eksd_pkg::MARKER_ASC,
                   eksd_pkg::MARKER_ASC, 8'h55, 8'h80};
    send_frame(1'b1);
    frame_bytes = {eksd_pkg::MARKER_ASC, 8'h7E, ESC_ASC};   // bad escape then ignored byte
    send_frame(1'b1);
    frame_bytes = {8'h12, eksd_pkg::MARKER_ASC};            // lone marker at frame end
    send_frame(1'b1);
    frame_bytes = {8'hAB};
    send_frame(1'b1);
    // marker held across a switch to descending mode
    frame_bytes = {eksd_pkg::MARKER_ASC};
    send_frame(1'b0);
    wait_drained();
    write_mode(1'b1);
    frame_bytes = {ESC_DESC};
    send_frame(1'b1);
    frame_bytes = {8'h00, eksd_pkg::MARKER_DESC, ESC_DESC, eksd_pkg::MARKER_DESC,
                   eksd_pkg::MARKER_DESC};
    send_frame(1'b1);
    frame_bytes = {eksd_pkg::MARKER_DESC, ESC_ASC};         // bad escape on the last byte
    send_frame(1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_mode(ph < 2 ? ph[0] ^ 1'b1 : 1'($urandom_range(0, 1)));
      phase_count = 0;
      if (ph == 3) begin
        // sink holds off while the source keeps offering back to back
        hold_request = 1'b1;
        burst = 1'b1;
      end
      while (phase_count < PHASE_ITEMS) begin
        build_frame();
        phase_count += frame_bytes.size();
        send_frame(1'b1);
        if (phase_count >= 40) burst = 1'b0;
      end
    end

    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("run covered %0d input bytes in %0d frames, %0d results compared",
             sent, sb.frames, sb.checked);
    $display("both marker modes, mode change inside a frame, %0d long sink hold-off(s)",
             holds);
    if (sb.expected_results.size() != 0) begin
      $display("%0d expected results never arrived", sb.expected_results.size());
    end
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
